// ===== hw/rtl/tcs_pkg.sv =====
// Shared types and constants for the text console cursor and scroll engine.
// Used by tcs_ctrl, tcs_datapath and text_console_cursor_scroll_core; no dependencies.
package tcs_pkg;

	localparam int REQ_W  = 2;
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 11;
	localparam int CELL_W = 16;
	localparam int POS_W  = 11;

	localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

	localparam logic [7:0] RESET_ATTR = 8'd10;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_SCROLL,
		ST_CLEAR,
		ST_RESP
	} ctl_state_t;

	typedef struct packed {
		logic load_req;
		logic exec;
		logic sweep_en;
		logic sweep_all;
		logic out_load;
		logic out_next;
	} dp_cmd_t;

	typedef struct packed {
		logic [REQ_W-1:0] req;
		logic             scroll;
		logic             sweep_last;
		logic             out_free;
	} dp_stat_t;

endpackage

// ===== hw/rtl/tcs_ctrl.sv =====
// Request sequencer of the text console engine: accept, execute, sweep, respond.
// Depends on tcs_pkg for the state, command and status types.
module tcs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tcs_pkg::dp_stat_t stat,
	output tcs_pkg::dp_cmd_t  cmd
);

	tcs_pkg::ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcs_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			tcs_pkg::ST_INIT: begin
				cmd.sweep_en  = 1'b1;
				cmd.sweep_all = 1'b1;
				if (stat.sweep_last) begin
					state_d = tcs_pkg::ST_IDLE;
				end
			end
			tcs_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = tcs_pkg::ST_EXEC;
				end
			end
			tcs_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				case (stat.req)
					tcs_pkg::REQ_PUT: begin
						if (stat.scroll) begin
							state_d = tcs_pkg::ST_SCROLL;
						end else if (stat.out_free) begin
							cmd.out_load = 1'b1;
							cmd.out_next = 1'b1;
							state_d      = tcs_pkg::ST_IDLE;
						end else begin
							state_d = tcs_pkg::ST_RESP;
						end
					end
					tcs_pkg::REQ_CLEAR: state_d = tcs_pkg::ST_CLEAR;
					default:            state_d = tcs_pkg::ST_RESP;
				endcase
			end
			tcs_pkg::ST_SCROLL: begin
				cmd.sweep_en = 1'b1;
				if (stat.sweep_last) begin
					state_d = tcs_pkg::ST_RESP;
				end
			end
			tcs_pkg::ST_CLEAR: begin
				cmd.sweep_en  = 1'b1;
				cmd.sweep_all = 1'b1;
				if (stat.sweep_last) begin
					state_d = tcs_pkg::ST_RESP;
				end
			end
			tcs_pkg::ST_RESP: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = tcs_pkg::ST_IDLE;
				end
			end
			default: state_d = tcs_pkg::ST_INIT;
		endcase
	end

endmodule

// ===== hw/rtl/tcs_datapath.sv =====
// Datapath of the text console engine: screen memory, cursor, scroll base,
// blanking sweep and output register. Depends on tcs_pkg; driven by tcs_ctrl.
module tcs_datapath #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [7:0]                   cfg_wr_data,
	input  logic [tcs_pkg::REQ_W-1:0]    req_type,
	input  logic [tcs_pkg::CHAR_W-1:0]   char_code,
	input  logic [tcs_pkg::IDX_W-1:0]    cell_index,
	input  tcs_pkg::dp_cmd_t             cmd,
	output tcs_pkg::dp_stat_t            stat,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [tcs_pkg::CELL_W-1:0]   cell_value,
	output logic [tcs_pkg::POS_W-1:0]    cursor_pos
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam int XW    = AW + 1;
	localparam int SW    = ((AW > tcs_pkg::IDX_W) ? AW : tcs_pkg::IDX_W) + 1;

	logic [7:0]                  attr_q;
	logic [tcs_pkg::REQ_W-1:0]   req_q;
	logic [tcs_pkg::CHAR_W-1:0]  char_q;
	logic [AW-1:0]               rd_addr_s1;
	logic                        rd_ok_s1;
	logic [CW-1:0]               col_q;
	logic [RW-1:0]               row_q;
	logic [AW-1:0]               lin_q;
	logic [AW-1:0]               phys_q;
	logic [AW-1:0]               top_base_q;
	logic [tcs_pkg::CELL_W-1:0]  blank_q;
	logic [AW-1:0]               sweep_cnt_q;
	logic [tcs_pkg::CELL_W-1:0]  mem [CELLS];
	logic [tcs_pkg::CELL_W-1:0]  rd_data_q;
	logic                        out_valid_q;
	logic [tcs_pkg::CELL_W-1:0]  out_cell_q;
	logic [tcs_pkg::POS_W-1:0]   out_pos_q;

	logic [SW-1:0]               rd_sum;
	logic [SW-1:0]               rd_wrap;
	logic                        rd_ok;
	logic [AW-1:0]               rd_addr;

	logic [CW-1:0]               col_n;
	logic [RW-1:0]               row_n;
	logic [AW-1:0]               lin_n;
	logic [AW-1:0]               phys_n;
	logic                        adv;
	logic                        scroll;
	logic                        put_we;
	logic [AW-1:0]               put_addr;
	logic [tcs_pkg::CELL_W-1:0]  put_data;
	logic [XW-1:0]               lin_x;
	logic [XW-1:0]               phys_x;

	logic                        sweep_last;
	logic [AW-1:0]               sweep_addr;
	logic [XW-1:0]               top_x;
	logic                        exec_put;

	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [tcs_pkg::CELL_W-1:0]  mem_wdata;
	logic [AW-1:0]               pos_sel;
	logic [AW+tcs_pkg::POS_W-1:0] pos_ext;

	// read address: visible index rotated by the top row base
	always_comb begin
		rd_sum  = SW'(cell_index) + SW'(top_base_q);
		rd_wrap = (rd_sum >= SW'(CELLS)) ? (rd_sum - SW'(CELLS)) : rd_sum;
		rd_ok   = SW'(cell_index) < SW'(CELLS);
		rd_addr = rd_wrap[AW-1:0];
	end

	always_comb begin
		col_n    = col_q;
		row_n    = row_q;
		lin_n    = lin_q;
		phys_n   = phys_q;
		adv      = 1'b0;
		put_we   = 1'b0;
		put_addr = phys_q;
		put_data = {attr_q, char_q};
		lin_x    = '0;
		phys_x   = '0;
		unique case (char_q)
			tcs_pkg::CH_NEWLINE: adv = 1'b1;
			tcs_pkg::CH_BACKSPACE: begin
				if (col_q != '0) begin
					col_n    = col_q - 1'b1;
					lin_n    = lin_q - 1'b1;
					phys_n   = phys_q - 1'b1;
					put_we   = 1'b1;
					put_addr = phys_q - 1'b1;
					put_data = {attr_q, tcs_pkg::CH_SPACE};
				end
			end
			tcs_pkg::CH_RETURN: begin
				col_n  = '0;
				lin_n  = lin_q - AW'(col_q);
				phys_n = phys_q - AW'(col_q);
			end
			default: begin
				put_we = 1'b1;
				if (col_q == CW'(COLUMNS - 1)) begin
					adv = 1'b1;
				end else begin
					col_n  = col_q + 1'b1;
					lin_n  = lin_q + 1'b1;
					phys_n = phys_q + 1'b1;
				end
			end
		endcase
		scroll = adv && (row_q == RW'(ROWS - 1));
		if (adv) begin
			col_n = '0;
			if (scroll) begin
				lin_n  = AW'((ROWS - 1) * COLUMNS);
				phys_n = top_base_q;
			end else begin
				row_n  = row_q + 1'b1;
				lin_x  = XW'(lin_q) - XW'(col_q) + XW'(COLUMNS);
				phys_x = XW'(phys_q) - XW'(col_q) + XW'(COLUMNS);
				if (phys_x >= XW'(CELLS)) begin
					phys_x = phys_x - XW'(CELLS);
				end
				lin_n  = lin_x[AW-1:0];
				phys_n = phys_x[AW-1:0];
			end
		end
	end

	always_comb begin
		sweep_addr = cmd.sweep_all ? sweep_cnt_q : (top_base_q + sweep_cnt_q);
		sweep_last = cmd.sweep_all ? (sweep_cnt_q == AW'(CELLS - 1))
		                           : (sweep_cnt_q == AW'(COLUMNS - 1));
		top_x      = XW'(top_base_q) + XW'(COLUMNS);
		exec_put   = cmd.exec && (req_q == tcs_pkg::REQ_PUT);
		mem_we     = cmd.sweep_en || (exec_put && put_we);
		mem_waddr  = cmd.sweep_en ? sweep_addr : put_addr;
		mem_wdata  = cmd.sweep_en ? blank_q : put_data;
		pos_sel    = cmd.out_next ? lin_n : lin_q;
		pos_ext    = {{tcs_pkg::POS_W{1'b0}}, pos_sel};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tcs_pkg::RESET_ATTR;
		end else if (cfg_wr_en) begin
			attr_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q      <= req_type;
			char_q     <= char_code;
			rd_addr_s1 <= rd_addr;
			rd_ok_s1   <= rd_ok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			lin_q       <= '0;
			phys_q      <= '0;
			top_base_q  <= '0;
			sweep_cnt_q <= '0;
			blank_q     <= {tcs_pkg::RESET_ATTR, tcs_pkg::CH_SPACE};
		end else begin
			if (cmd.exec) begin
				blank_q <= {attr_q, tcs_pkg::CH_SPACE};
			end
			if (exec_put) begin
				col_q  <= col_n;
				row_q  <= row_n;
				lin_q  <= lin_n;
				phys_q <= phys_n;
			end else if (cmd.exec && (req_q == tcs_pkg::REQ_CLEAR)) begin
				col_q      <= '0;
				row_q      <= '0;
				lin_q      <= '0;
				phys_q     <= '0;
				top_base_q <= '0;
			end
			if (cmd.sweep_en) begin
				sweep_cnt_q <= sweep_last ? '0 : (sweep_cnt_q + 1'b1);
				if (sweep_last && !cmd.sweep_all) begin
					top_base_q <= (top_x >= XW'(CELLS)) ? '0 : top_x[AW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.exec && (req_q == tcs_pkg::REQ_READ)) begin
			rd_data_q <= mem[rd_addr_s1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_cell_q <= (!cmd.out_next && (req_q == tcs_pkg::REQ_READ) && rd_ok_s1)
			              ? rd_data_q : '0;
			out_pos_q  <= pos_ext[tcs_pkg::POS_W-1:0];
		end
	end

	assign out_valid       = out_valid_q;
	assign cell_value      = out_cell_q;
	assign cursor_pos      = out_pos_q;
	assign stat.req        = req_q;
	assign stat.scroll     = scroll;
	assign stat.sweep_last = sweep_last;
	assign stat.out_free   = !out_valid_q || out_ready;

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("output register overwritten while occupied");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(col_q) < COLUMNS) && (int'(row_q) < ROWS))
		else $error("cursor outside the screen");

	a_cursor_linear: assert property (@(posedge clk) disable iff (!arst_n)
		int'(lin_q) == int'(row_q) * COLUMNS + int'(col_q))
		else $error("linear cursor out of step with row and column");

	a_phys_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(phys_q) < CELLS) && (int'(top_base_q) < CELLS))
		else $error("physical cursor or top base beyond the screen store");

endmodule

// ===== hw/rtl/text_console_cursor_scroll_core.sv =====
// Each request is taken in idle and run in execute. A plain put loads its result there
// if the output register is free, else in respond; a read loads it in respond. A put
// that scrolls sweeps one row and a clear sweeps every cell before respond. One request
// is in flight at a time; the output register lets the next one enter while a result
// waits. Sweeps blank one cell per cycle; after reset a sweep blanks all ROWS*COLUMNS
// cells with attribute 10 before in_ready rises; attribute writes are taken throughout.
module text_console_cursor_scroll_core #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [7:0]                  cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [tcs_pkg::REQ_W-1:0]   req_type,
	input  logic [tcs_pkg::CHAR_W-1:0]  char_code,
	input  logic [tcs_pkg::IDX_W-1:0]   cell_index,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [tcs_pkg::CELL_W-1:0]  cell_value,
	output logic [tcs_pkg::POS_W-1:0]   cursor_pos
);

	tcs_pkg::dp_cmd_t  cmd;
	tcs_pkg::dp_stat_t stat;

	tcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tcs_datapath #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req_type    (req_type),
		.char_code   (char_code),
		.cell_index  (cell_index),
		.cmd         (cmd),
		.stat        (stat),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.cell_value  (cell_value),
		.cursor_pos  (cursor_pos)
	);

endmodule

// ===== test/text_console_cursor_scroll_checker.sv =====
// Checker for text_console_cursor_scroll_core: tracks the screen, cursor and attribute,
// predicts each result and compares it with what the core returns.
// Depends on tcs_pkg for widths and codes.
module text_console_cursor_scroll_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [7:0]                  cfg_wr_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [tcs_pkg::REQ_W-1:0]   req_type,
	input  logic [tcs_pkg::CHAR_W-1:0]  char_code,
	input  logic [tcs_pkg::IDX_W-1:0]   cell_index,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [tcs_pkg::CELL_W-1:0]  cell_value,
	input  logic [tcs_pkg::POS_W-1:0]   cursor_pos,
	output int                          mismatch_count,
	output int                          pending_results
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CELLS = ROWS * COLUMNS;

	typedef struct packed {
		logic [tcs_pkg::CELL_W-1:0] cell_data;
		logic [tcs_pkg::POS_W-1:0]  pos;
	} console_result_t;

	logic [tcs_pkg::CELL_W-1:0] screen [CELLS];
	int unsigned                cur_col;
	int unsigned                cur_row;
	int unsigned                top_line;
	logic [7:0]                 attr;
	console_result_t            awaited [$];

	initial begin
		mismatch_count  = 0;
		pending_results = 0;
	end

	function automatic logic [tcs_pkg::CELL_W-1:0] blank_cell(logic [7:0] a);
		return {a, tcs_pkg::CH_SPACE};
	endfunction

	function automatic int unsigned cell_addr(int unsigned r, int unsigned c);
		return ((r + top_line) % ROWS) * COLUMNS + (c % COLUMNS);
	endfunction

	task automatic wipe_screen();
		for (int i = 0; i < CELLS; i++)
			screen[i] = blank_cell(attr);
		cur_col  = 0;
		cur_row  = 0;
		top_line = 0;
	endtask

	task automatic print_char(logic [tcs_pkg::CHAR_W-1:0] ch);
		case (ch)
			tcs_pkg::CH_NEWLINE: begin
				cur_col = 0;
				cur_row++;
			end
			tcs_pkg::CH_BACKSPACE: begin
				if (cur_col > 0) begin
					cur_col--;
					screen[cell_addr(cur_row, cur_col)] = blank_cell(attr);
				end
			end
			tcs_pkg::CH_RETURN: cur_col = 0;
			default: begin
				screen[cell_addr(cur_row, cur_col)] = {attr, ch};
				cur_col++;
			end
		endcase
		if (cur_col >= COLUMNS) begin
			cur_col = 0;
			cur_row++;
		end
		// old top line becomes the new bottom line
		if (cur_row >= ROWS) begin
			for (int c = 0; c < COLUMNS; c++)
				screen[top_line * COLUMNS + c] = blank_cell(attr);
			top_line = (top_line + 1) % ROWS;
			cur_row  = ROWS - 1;
		end
	endtask

	task automatic console_step(
		input  logic [tcs_pkg::REQ_W-1:0]  req,
		input  logic [tcs_pkg::CHAR_W-1:0] ch,
		input  logic [tcs_pkg::IDX_W-1:0]  idx,
		output console_result_t            res
	);
		res.cell_data = '0;
		case (req)
			tcs_pkg::REQ_PUT: print_char(ch);
			tcs_pkg::REQ_READ: begin
				if (idx < CELLS)
					res.cell_data = screen[cell_addr(idx / COLUMNS, idx % COLUMNS)];
			end
			tcs_pkg::REQ_CLEAR: wipe_screen();
			default: ;
		endcase
		res.pos = tcs_pkg::POS_W'(cur_row * COLUMNS + cur_col);
	endtask

	task automatic report_mismatch(string what, logic [tcs_pkg::CELL_W-1:0] want,
		logic [tcs_pkg::CELL_W-1:0] got);
		$display("%0t ns: %s mismatch, expected %h got %h", $time, what, want, got);
		mismatch_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		console_result_t want;
		console_result_t fresh;
		if (!arst_n) begin
			attr = tcs_pkg::RESET_ATTR;
			wipe_screen();
			awaited.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (awaited.size() == 0) begin
					report_mismatch("unrequested result", '0, cell_value);
				end else begin
					want = awaited.pop_front();
					if (cell_value !== want.cell_data)
						report_mismatch("cell_value", want.cell_data, cell_value);
					if (cursor_pos !== want.pos)
						report_mismatch("cursor_pos", tcs_pkg::CELL_W'(want.pos),
							tcs_pkg::CELL_W'(cursor_pos));
				end
			end
			if (in_valid && in_ready) begin
				console_step(req_type, char_code, cell_index, fresh);
				awaited.push_back(fresh);
			end
			if (cfg_wr_en)
				attr = cfg_wr_data;
		end
		pending_results = awaited.size();
	end

endmodule

// ===== test/tb_text_console_cursor_scroll_core.sv =====
// Testbench top for text_console_cursor_scroll_core: drives requests and attribute
// writes with random idling and gives the verdict. Depends on tcs_pkg, the core and
// text_console_cursor_scroll_checker.
module tb_text_console_cursor_scroll_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = ROWS * COLUMNS;
	localparam logic [tcs_pkg::REQ_W-1:0] REQ_SPARE = 2'd3;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       cfg_wr_en = 1'b0;
	logic [7:0]                 cfg_wr_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic [tcs_pkg::REQ_W-1:0]  req_type = '0;
	logic [tcs_pkg::CHAR_W-1:0] char_code = '0;
	logic [tcs_pkg::IDX_W-1:0]  cell_index = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic [tcs_pkg::CELL_W-1:0] cell_value;
	logic [tcs_pkg::POS_W-1:0]  cursor_pos;
	int                         mismatch_count;
	int                         pending_results;

	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int rx_hold = 0;

	always #10 clk = ~clk;

	text_console_cursor_scroll_core #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .char_code(char_code), .cell_index(cell_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.cell_value(cell_value), .cursor_pos(cursor_pos)
	);

	text_console_cursor_scroll_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .char_code(char_code), .cell_index(cell_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.cell_value(cell_value), .cursor_pos(cursor_pos),
		.mismatch_count(mismatch_count), .pending_results(pending_results)
	);

	task automatic send_req(logic [tcs_pkg::REQ_W-1:0] r, logic [tcs_pkg::CHAR_W-1:0] c,
		logic [tcs_pkg::IDX_W-1:0] i);
		int gap;
		gap = tx_idle ? $urandom_range(0, 11) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_type   = r;
		char_code  = c;
		cell_index = i;
		in_valid   = 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic put_char(logic [tcs_pkg::CHAR_W-1:0] c);
		send_req(tcs_pkg::REQ_PUT, c, tcs_pkg::IDX_W'($urandom_range(0, 2047)));
	endtask

	task automatic read_cell(logic [tcs_pkg::IDX_W-1:0] i);
		send_req(tcs_pkg::REQ_READ, tcs_pkg::CHAR_W'($urandom_range(0, 255)), i);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (pending_results != 0) @(negedge clk);
	endtask

	task automatic set_attribute(logic [7:0] a);
		wait_drained();
		repeat (2) @(negedge clk);
		cfg_wr_data = a;
		cfg_wr_en   = 1'b1;
		@(negedge clk);
		cfg_wr_en   = 1'b0;
	endtask

	task automatic random_traffic(int count);
		int issued;
		int kind;
		int len;
		int term;
		issued = 0;
		while (issued < count) begin
			if ($urandom_range(0, 7) == 0) begin
				tx_idle = $urandom_range(0, 3) != 0;
				rx_idle = $urandom_range(0, 3) != 0;
			end
			kind = $urandom_range(0, 99);
			if (kind < 55) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 100) : $urandom_range(0, 8);
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(0, 9) == 0)
						put_char(tcs_pkg::CHAR_W'($urandom_range(0, 255)));
					else
						put_char(tcs_pkg::CHAR_W'($urandom_range(32, 126)));
				end
				issued += len;
				term = $urandom_range(0, 9);
				if (term < 6) begin
					put_char(tcs_pkg::CH_NEWLINE);
					issued++;
				end else if (term < 8) begin
					put_char(tcs_pkg::CH_RETURN);
					issued++;
				end
			end else if (kind < 70) begin
				len = $urandom_range(1, 4);
				repeat (len) put_char(tcs_pkg::CH_BACKSPACE);
				issued += len;
			end else if (kind < 90) begin
				if ($urandom_range(0, 9) == 0)
					read_cell(tcs_pkg::IDX_W'($urandom_range(CELLS, 2047)));
				else
					read_cell(tcs_pkg::IDX_W'($urandom_range(0, CELLS - 1)));
				issued++;
			end else if (kind < 93) begin
				send_req(REQ_SPARE, tcs_pkg::CHAR_W'($urandom_range(0, 255)),
					tcs_pkg::IDX_W'($urandom_range(0, 2047)));
				issued++;
			end else if (kind < 99) begin
				len = $urandom_range(1, 6);
				repeat (len) put_char(tcs_pkg::CH_NEWLINE);
				issued += len;
			end else begin
				send_req(tcs_pkg::REQ_CLEAR, tcs_pkg::CHAR_W'($urandom_range(0, 255)),
					tcs_pkg::IDX_W'($urandom_range(0, 2047)));
				issued++;
			end
		end
	endtask

	initial begin : drain
		int w;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (rx_hold > 0) begin
				out_ready = 1'b0;
				repeat (rx_hold) @(negedge clk);
				rx_hold = 0;
			end
			w = rx_idle ? $urandom_range(0, 11) : 0;
			if (w > 0) begin
				out_ready = 1'b0;
				repeat (w) @(negedge clk);
			end
			out_ready = 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	initial begin
		#200_000_000;
		$display("text_console_cursor_scroll_core verification failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		while (!in_ready) @(negedge clk);

		read_cell(11'd0);
		put_char(8'h41);
		put_char(8'h00);
		put_char(8'hFF);
		put_char(tcs_pkg::CH_BACKSPACE);
		put_char(tcs_pkg::CH_RETURN);
		put_char(tcs_pkg::CH_BACKSPACE);
		put_char(8'h7F);
		put_char(tcs_pkg::CH_NEWLINE);
		send_req(REQ_SPARE, 8'hFF, 11'h7FF);
		read_cell(11'd0);
		read_cell(11'd1);
		read_cell(11'd1999);
		read_cell(11'd2000);
		read_cell(11'h7FF);
		send_req(tcs_pkg::REQ_CLEAR, 8'h00, 11'd0);
		read_cell(11'd0);

		set_attribute(8'hFF);
		put_char(8'h5A);
		put_char(8'h61);
		put_char(tcs_pkg::CH_BACKSPACE);
		read_cell(11'd1);
		read_cell(11'd0);
		set_attribute(8'h00);
		put_char(8'h80);
		read_cell(11'd1);

		// stall the result side while newlines push the screen into scrolling
		wait_drained();
		rx_hold = 400;
		tx_idle = 1'b0;
		for (int k = 0; k < 40; k++)
			put_char((k % 4 == 3) ? 8'h23 : tcs_pkg::CH_NEWLINE);
		wait_drained();
		tx_idle = 1'b1;

		for (int p = 0; p < 6; p++) begin
			if (p == 0)
				set_attribute(8'h55);
			else if (p == 5)
				set_attribute(8'hFF);
			else
				set_attribute(8'($urandom_range(0, 255)));
			random_traffic(145);
		end

		wait_drained();
		repeat (CELLS + 100) @(negedge clk);
		if (mismatch_count == 0)
			$display("text_console_cursor_scroll_core verification clean");
		else
			$display("text_console_cursor_scroll_core verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/tcs_pkg.sv
hw/rtl/tcs_ctrl.sv
hw/rtl/tcs_datapath.sv
hw/rtl/text_console_cursor_scroll_core.sv
test/text_console_cursor_scroll_checker.sv
test/tb_text_console_cursor_scroll_core.sv
